FILE: sv/lz3d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz3d_pkg
// Shared types and constants for the three-stream LZ decompressor.
// ----------------------------------------------------------------------------
package lz3d_pkg;

  // input stream codes
  localparam logic [1:0] ACT_CONTROL = 2'd0;
  localparam logic [1:0] ACT_COUNT   = 2'd1;
  localparam logic [1:0] ACT_DATA    = 2'd2;
  localparam logic [1:0] NEED_DONE   = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_DISTANCE = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;
  localparam logic [1:0] ERR_KIND     = 2'd3;

  // configuration register indexes
  localparam logic [0:0] REG_OUTPUT_SIZE   = 1'b0;
  localparam logic [0:0] REG_STRICT_LENGTH = 1'b1;

  localparam int          HIST_AW    = 12;
  localparam logic [11:0] DIST_MASK  = 12'hFFF;
  localparam logic [8:0]  LEN_EXTRA  = 9'h012;

  // what the decoder expects next
  typedef enum logic [4:0] {
    K_CONTROL  = 5'b00001,
    K_COUNT_HI = 5'b00010,
    K_COUNT_LO = 5'b00100,
    K_LITERAL  = 5'b01000,
    K_LENGTH   = 5'b10000
  } kind_t;

  // sequencer state
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_COPY = 4'b0010,
    S_EMIT = 4'b0100,
    S_WAIT = 4'b1000
  } state_t;

  // stream code wanted for a kind
  function automatic logic [1:0] want_of(input kind_t k);
    logic [1:0] w;
    w = ACT_CONTROL;
    unique case (k)
      K_CONTROL:              w = ACT_CONTROL;
      K_COUNT_HI, K_COUNT_LO: w = ACT_COUNT;
      default:                w = ACT_DATA;
    endcase
    return w;
  endfunction

endpackage

FILE: sv/lz_three_stream_decompressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_three_stream_decompressor
// Yay0-style decoder: tagged input bytes in, beats of up to eight bytes out.
// ----------------------------------------------------------------------------
// A control, count or literal byte gives one beat, which is registered
// through the S_WAIT state; the next item is taken once that beat is taken.
// A copy reads each byte from the history memory into a register and writes
// it back before the next read, hands each full or final beat out through
// S_EMIT and pauses while an output beat waits. One item is in flight at a time.
// Reset (rst_n low, synchronous) clears all control state; the history
// memory is not cleared and needs no clearing pass.
module lz_three_stream_decompressor #(
  parameter int SIZE_BITS        = 24,
  parameter int BYTES_PER_RESULT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [23:0] cfg_data,
  // input: tdata = byte_value[7:0]; tuser = action[1:0]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic [1:0]  in_tuser,
  // output: tdata = out_bytes[63:0], out_count[67:64], error_code[69:68], pad
  //         tuser = next_need[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);
  import lz3d_pkg::*;

  localparam int LANE_W = (BYTES_PER_RESULT > 1) ? $clog2(BYTES_PER_RESULT) : 1;
  localparam logic [SIZE_BITS-1:0] SZ_ONE = SIZE_BITS'(1);

  // configuration
  logic [SIZE_BITS-1:0] output_size_r;
  logic                 strict_r;

  // decoder state
  state_t               state_r;
  logic [SIZE_BITS-1:0] written_r;
  logic [7:0]           ctrl_r;
  logic [3:0]           bits_r;
  logic [7:0]           count_high_r;
  kind_t                kind_r;
  logic [12:0]          dist_r;
  logic [1:0]           halt_r;

  // copy engine
  logic [8:0]           copy_left_r;
  logic                 rd_pend_r;
  logic [63:0]          acc_r;
  logic [3:0]           lane_r;

  // output register
  logic [63:0]          ob_r;
  logic [3:0]           oc_r;
  logic [1:0]           oe_r;
  logic [1:0]           on_r;
  logic                 olast_r;
  logic                 ovalid_r;

  // history memory
  logic [7:0]           hist [0:4095];
  logic [7:0]           rd_data_r;
  logic                 wr_en;
  logic [HIST_AW-1:0]   wr_addr;
  logic [7:0]           wr_data;
  logic                 rd_en;
  logic [HIST_AW-1:0]   rd_addr;

  logic                 done;
  logic                 in_fire;
  logic                 out_fire;

  assign done      = (halt_r != ERR_NONE) || (written_r >= output_size_r);
  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE) && !ovalid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = ovalid_r && out_tready;

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {2'b00, oe_r, oc_r, ob_r};
  assign out_tlast  = olast_r;
  assign out_tuser  = on_r;

  // memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) hist[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= hist[rd_addr];
  end

  // read only once the previous copy byte has been written back
  assign rd_en   = (state_r == S_COPY) && (copy_left_r != 9'd0) && !ovalid_r && !rd_pend_r;
  assign rd_addr = HIST_AW'(written_r - SIZE_BITS'(dist_r));
  assign wr_addr = HIST_AW'(written_r);

  // the byte written back: the literal, or the copy byte read last cycle
  always_comb begin
    wr_en   = 1'b0;
    wr_data = in_tdata;
    if (in_fire && !done && kind_r == K_LITERAL && in_tuser == ACT_DATA) begin
      wr_en = 1'b1;
    end else if (state_r == S_COPY && rd_pend_r) begin
      wr_en   = 1'b1;
      wr_data = rd_data_r;
    end
  end

  // decode and sequence
  always_ff @(posedge clk) begin
    logic [15:0] word;
    logic [8:0]  len;
    logic [SIZE_BITS-1:0] avail;
    logic [SIZE_BITS-1:0] end_cnt;
    logic        advance;
    kind_t       nk;
    state_t      st_v;
    logic [63:0] ob_v;
    logic [3:0]  oc_v;
    logic [1:0]  oe_v;
    if (!rst_n) begin
      output_size_r <= '0;
      strict_r      <= 1'b1;
      state_r       <= S_IDLE;
      written_r     <= '0;
      ctrl_r        <= '0;
      bits_r        <= '0;
      count_high_r  <= '0;
      kind_r        <= K_CONTROL;
      dist_r        <= '0;
      halt_r        <= ERR_NONE;
      copy_left_r   <= '0;
      rd_pend_r     <= 1'b0;
      lane_r        <= '0;
      ovalid_r      <= 1'b0;
      olast_r       <= 1'b0;
      on_r          <= ACT_CONTROL;
    end else begin
      advance = 1'b0;
      len     = '0;
      word    = {count_high_r, in_tdata};
      avail   = output_size_r - written_r;
      end_cnt = written_r + SIZE_BITS'(copy_left_r);
      nk      = (bits_r <= 4'd1) ? K_CONTROL : (ctrl_r[6] ? K_LITERAL : K_COUNT_HI);
      st_v    = S_WAIT;
      ob_v    = '0;
      oc_v    = '0;
      oe_v    = ERR_NONE;
      if (cfg_valid) begin
        if (cfg_index == REG_OUTPUT_SIZE) output_size_r <= SIZE_BITS'(cfg_data);
        else                              strict_r <= cfg_data[0];
      end
      if (out_fire) ovalid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            // default: one empty beat
            olast_r <= 1'b1;
            if (done) begin
              oe_v = halt_r;
            end else if (in_tuser != want_of(kind_r)) begin
              halt_r <= ERR_KIND;
              oe_v    = ERR_KIND;
            end else begin
              unique case (kind_r)
                K_CONTROL: begin
                  ctrl_r <= in_tdata;
                  bits_r <= 4'd8;
                  kind_r <= in_tdata[7] ? K_LITERAL : K_COUNT_HI;
                end
                K_COUNT_HI: begin
                  count_high_r <= in_tdata;
                  kind_r       <= K_COUNT_LO;
                end
                K_LITERAL: begin
                  written_r <= written_r + SZ_ONE;
                  ob_v       = {56'd0, in_tdata};
                  oc_v       = 4'd1;
                  advance    = 1'b1;
                end
                default: begin
                  // count low byte or extended length: may start a copy
                  if (kind_r == K_COUNT_LO) begin
                    dist_r <= 13'(word[11:0] & DIST_MASK) + 13'd1;
                    len     = 9'(word[15:12]) + 9'd2;
                  end else begin
                    len     = 9'(in_tdata) + LEN_EXTRA;
                  end
                  if (kind_r == K_COUNT_LO && word[15:12] == 4'd0) begin
                    kind_r <= K_LENGTH;
                  end else if (((kind_r == K_COUNT_LO) ?
                                (SIZE_BITS'(word[11:0]) + SZ_ONE) :
                                SIZE_BITS'(dist_r)) > written_r) begin
                    halt_r <= ERR_DISTANCE;
                    oe_v    = ERR_DISTANCE;
                  end else if (SIZE_BITS'(len) > avail && strict_r) begin
                    halt_r <= ERR_OVERFLOW;
                    oe_v    = ERR_OVERFLOW;
                  end else begin
                    copy_left_r <= (SIZE_BITS'(len) > avail) ? 9'(avail) : len;
                    lane_r      <= '0;
                    acc_r       <= '0;
                    rd_pend_r   <= 1'b0;
                    st_v         = S_COPY;
                  end
                end
              endcase
            end
            ob_r    <= ob_v;
            oc_r    <= oc_v;
            oe_r    <= oe_v;
            state_r <= st_v;
          end
        end

        S_COPY: begin
          if (rd_pend_r) begin
            // write back the byte read last cycle and pack it
            written_r <= written_r + SZ_ONE;
            acc_r[8*LANE_W'(lane_r) +: 8] <= rd_data_r;
            lane_r <= lane_r + 4'd1;
            // hand a full or final beat to the output register
            if (copy_left_r == 9'd0 || lane_r + 4'd1 == 4'(BYTES_PER_RESULT)) begin
              state_r <= S_EMIT;
            end
          end else if (!ovalid_r && copy_left_r == 9'd0) begin
            // empty copy, cut at size
            ob_r     <= '0;
            oc_r     <= '0;
            oe_r     <= ERR_NONE;
            olast_r  <= 1'b1;
            advance   = 1'b1;
            state_r  <= S_WAIT;
          end
          rd_pend_r <= rd_en;
          if (rd_en) copy_left_r <= copy_left_r - 9'd1;
        end

        S_EMIT: begin
          ob_r     <= acc_r;
          oc_r     <= lane_r;
          oe_r     <= ERR_NONE;
          on_r     <= (end_cnt >= output_size_r) ? NEED_DONE : want_of(nk);
          olast_r  <= (copy_left_r == 9'd0);
          ovalid_r <= 1'b1;
          acc_r    <= '0;
          lane_r   <= '0;
          if (copy_left_r == 9'd0) begin
            advance  = 1'b1;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_COPY;
          end
        end

        S_WAIT: begin
          on_r     <= done ? NEED_DONE : want_of(kind_r);
          ovalid_r <= 1'b1;
          state_r  <= S_IDLE;
        end

        default: state_r <= S_IDLE;
      endcase

      // step to the next control flag
      if (advance) begin
        ctrl_r <= {ctrl_r[6:0], 1'b0};
        bits_r <= (bits_r != 4'd0) ? bits_r - 4'd1 : 4'd0;
        kind_r <= nk;
      end
    end
  end

`ifndef SYNTHESIS
  // no item is taken while a beat waits
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> !in_tready) else $error("input taken while beat pending");
  // a halt code, once set, stays
  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (halt_r != ERR_NONE) |=> (halt_r == $past(halt_r))) else $error("halt changed");
  // beats never hold more than a lane count
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (oc_r <= 4'(BYTES_PER_RESULT))) else $error("bad count");
`endif

endmodule

FILE: dv/lz_three_stream_decompressor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_three_stream_decompressor_tb
// Self-checking bench for the three-stream LZ decoder. Tagged bytes are fed
// as well-formed streams with random content, each beat is predicted by a
// behavioural decoder in the bench and compared field by field with the
// output. Covers literals, short and long copies, size cut-off, finished and
// halted states, and one of the three halting errors at the end.
// ----------------------------------------------------------------------------
module lz_three_stream_decompressor_tb;
  import lz3d_pkg::*;

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic [1:0]  need;
    logic [1:0]  err;
    logic        last;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = REG_OUTPUT_SIZE;
  logic [23:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = ACT_CONTROL;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  lz_three_stream_decompressor i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  // decoder model state
  logic [7:0]  hist [0:4095];
  logic [23:0] written;
  logic [7:0]  ctl_shift;
  logic [3:0]  bits_left;
  logic [7:0]  cnt_hi;
  kind_t       kind;
  logic [12:0] distance;
  logic [1:0]  halt_err;
  logic [23:0] out_size;
  logic        strict;

  beat_t       pending_beats[$];
  int          mismatches = 0;
  int          burst_left = 0;
  int          stall_req = 0;
  logic [7:0]  next_lo = '0;

  // ---------------------------------------------------------------- model
  function automatic logic decoder_done();
    return halt_err != ERR_NONE || written >= out_size;
  endfunction

  function automatic void set_kind_from_flag();
    kind = ctl_shift[7] ? K_LITERAL : K_COUNT_HI;
  endfunction

  function automatic void next_flag();
    ctl_shift = ctl_shift << 1;
    if (bits_left > 0) bits_left--;
    if (bits_left == 0) kind = K_CONTROL;
    else set_kind_from_flag();
  endfunction

  function automatic void store(input logic [7:0] b);
    hist[written[11:0]] = b;
    written = written + 24'd1;
  endfunction

  // expand one accepted byte into its predicted beats
  function automatic void decode_byte(input logic [1:0] act, input logic [7:0] b);
    beat_t       res[$];
    beat_t       bt;
    logic [15:0] word;
    logic [31:0] len, avail;
    logic [1:0]  nd;
    logic [7:0]  cb;
    int          lane;
    res = {};
    bt = '0;
    len = 0;
    if (decoder_done()) begin
      bt.err = halt_err;
      res.push_back(bt);
    end else if (act != want_of(kind)) begin
      halt_err = ERR_KIND;
      bt.err = ERR_KIND;
      res.push_back(bt);
    end else begin
      case (kind)
        K_CONTROL: begin
          ctl_shift = b;
          bits_left = 4'd8;
          set_kind_from_flag();
        end
        K_COUNT_HI: begin
          cnt_hi = b;
          kind = K_COUNT_LO;
        end
        K_COUNT_LO: begin
          word = {cnt_hi, b};
          distance = {1'b0, word[11:0]} + 13'd1;
          if (word[15:12] == 4'd0) kind = K_LENGTH;
          else len = word[15:12] + 2;
        end
        K_LITERAL: begin
          store(b);
          next_flag();
          bt.bytes = {56'd0, b};
          bt.count = 4'd1;
        end
        default: len = b + LEN_EXTRA;
      endcase
      if (len != 0) begin
        avail = out_size - written;
        if (distance > written) begin
          halt_err = ERR_DISTANCE;
          bt.err = ERR_DISTANCE;
        end else if (len > avail && strict) begin
          halt_err = ERR_OVERFLOW;
          bt.err = ERR_OVERFLOW;
        end else begin
          if (len > avail) len = avail;
          lane = 0;
          for (int i = 0; i < len; i++) begin
            cb = hist[(written - distance) & 24'hFFF];
            store(cb);
            bt.bytes[8*lane +: 8] = cb;
            lane++;
            if (lane == 8 || i + 1 == len) begin
              bt.count = 4'(lane);
              res.push_back(bt);
              bt = '0;
              lane = 0;
            end
          end
          next_flag();
        end
      end
      if (res.size() == 0) res.push_back(bt);
    end
    if (decoder_done()) nd = NEED_DONE;
    else nd = want_of(kind);
    foreach (res[i]) begin
      res[i].need = nd;
      res[i].last = (i == res.size() - 1);
      pending_beats.push_back(res[i]);
    end
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_byte(input logic [1:0] act, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      // valid is already low here; idle for a while before the next burst
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= act;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    decode_byte(act, b);
    if (burst_left == 0) in_tvalid <= 1'b0;
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_OUTPUT_SIZE) out_size = val;
    else strict = val[0];
    @(posedge clk);
  endtask

  // hold input off until every predicted beat has come back
  task automatic drain();
    if (burst_left != 0) in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one well-formed byte for the current decoder position
  task automatic send_legal();
    int          maxd, d;
    logic [3:0]  nib;
    logic [15:0] word;
    case (kind)
      K_CONTROL: send_byte(ACT_CONTROL, (written == 0) ? 8'hFF : 8'($urandom));
      K_COUNT_HI: begin
        maxd = (written > 4096) ? 4096 : written;
        d = ($urandom_range(0, 1) == 0) ? $urandom_range(1, (maxd < 8) ? maxd : 8)
                                        : $urandom_range(1, maxd);
        nib = 4'($urandom);
        word = {nib, 12'(d - 1)};
        next_lo = word[7:0];
        send_byte(ACT_COUNT, word[15:8]);
      end
      K_COUNT_LO: send_byte(ACT_COUNT, next_lo);
      K_LENGTH:
        send_byte(ACT_DATA, ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(0, 15)));
      default: send_byte(ACT_DATA, 8'($urandom));
    endcase
  endtask

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin : rx_stall
    static int mode = 0;
    static int left = 0;
    static int hold = 0;
    if (stall_req != 0) begin
      hold = stall_req;
      stall_req = 0;
    end
    if (left == 0) begin
      mode = $urandom_range(0, 2);
      left = $urandom_range(16, 96);
    end
    left--;
    if (hold > 0) begin
      hold--;
      out_tready <= 1'b0;
    end else begin
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        default: out_tready <= (left % 4 == 0);
      endcase
    end
  end

  // compare each beat that will be taken at the next edge
  always @(negedge clk) begin : beat_check
    beat_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[63:0], out_tdata[67:64], out_tuser, out_tdata[69:68], out_tlast};
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", got);
      end else begin
        want = pending_beats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("beat mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // end the run when nothing moves for too long
  always @(negedge clk) begin : watchdog
    static int idle = 0;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle = 0;
    else
      idle++;
    if (idle >= 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_zero_size();
    write_reg(REG_STRICT_LENGTH, 1'b1);
    write_reg(REG_OUTPUT_SIZE, 24'd0);
    send_byte(ACT_CONTROL, 8'hFF);
    send_byte(ACT_DATA, 8'h12);
    drain();
    write_reg(REG_OUTPUT_SIZE, 24'hFFFFFF);
  endtask

  task automatic test_directed();
    send_byte(ACT_CONTROL, 8'hC0);
    send_byte(ACT_DATA, 8'h00);
    send_byte(ACT_DATA, 8'hFF);
    // longest nibble length, distance one
    send_byte(ACT_COUNT, 8'hF0); send_byte(ACT_COUNT, 8'h00);
    // extended length, largest length byte
    send_byte(ACT_COUNT, 8'h00); send_byte(ACT_COUNT, 8'h01); send_byte(ACT_DATA, 8'hFF);
    send_byte(ACT_COUNT, 8'h10); send_byte(ACT_COUNT, 8'h00);
    send_byte(ACT_COUNT, 8'h20); send_byte(ACT_COUNT, 8'h63);
    // extended length, smallest length byte
    send_byte(ACT_COUNT, 8'h00); send_byte(ACT_COUNT, 8'h00); send_byte(ACT_DATA, 8'h00);
    send_byte(ACT_COUNT, 8'hF1); send_byte(ACT_COUNT, 8'h23);
    send_byte(ACT_CONTROL, 8'h55);
    drain();
  endtask

  task automatic test_random_strict();
    for (int i = 0; i < 180; i++) begin
      if (i == 60) stall_req = 300;
      send_legal();
    end
    drain();
  endtask

  task automatic test_size_cut();
    write_reg(REG_STRICT_LENGTH, 1'b0);
    write_reg(REG_OUTPUT_SIZE, written + 24'd40);
    while (!decoder_done()) send_legal();
    send_byte(ACT_DATA, 8'hA5);
    send_byte(ACT_COUNT, 8'h5A);
    drain();
    write_reg(REG_OUTPUT_SIZE, 24'hFFFFFF);
    for (int i = 0; i < 40; i++) send_legal();
    drain();
    write_reg(REG_STRICT_LENGTH, 1'b1);
  endtask

  task automatic test_halt();
    int which;
    which = $urandom_range(1, 3);
    if (which == 1 && written >= 4096) which = 2;
    while (kind != K_COUNT_HI) send_legal();
    if (which == 1) begin
      send_byte(ACT_COUNT, 8'h1F);
      send_byte(ACT_COUNT, 8'hFF);
    end else if (which == 2) begin
      drain();
      write_reg(REG_OUTPUT_SIZE, written + 24'd1);
      send_byte(ACT_COUNT, 8'hF0);
      send_byte(ACT_COUNT, 8'h00);
    end else begin
      send_byte(2'd3, 8'h00);
    end
    for (int i = 0; i < 4; i++) send_byte(2'($urandom), 8'($urandom));
    drain();
  endtask

  initial begin
    foreach (hist[i]) hist[i] = '0;
    written = '0; ctl_shift = '0; bits_left = '0; cnt_hi = '0;
    kind = K_CONTROL; distance = '0; halt_err = ERR_NONE;
    out_size = '0; strict = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_size();
    test_directed();
    test_random_strict();
    test_size_cut();
    test_halt();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: lz_three_stream_decompressor.f
sv/lz3d_pkg.sv
sv/lz_three_stream_decompressor.sv
dv/lz_three_stream_decompressor_tb.sv
